// ----- hdl/tmdsb_pkg.sv -----
`timescale 1ns / 1ps

package tmdsb_pkg;

    // sample and frame geometry
    localparam int SAMPLE_W   = 16;
    localparam int FRAME_MAX  = 64;
    localparam int FRAME_AW   = 6;
    localparam int CNT_W      = 7;
    localparam int HIST_DEPTH = 16;
    localparam int HIST_AW    = 4;

    // lag search
    localparam int LAG_W    = 6;
    localparam int MAXLAG_W = 5;
    localparam int LAG_CAP  = 16;
    localparam int THR_W    = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd9830;

    // correlation arithmetic widths
    localparam int PROD_W  = 32;
    localparam int SQ_W    = 31;
    localparam int ACC_W   = 36;
    localparam int XY_W    = 37;
    localparam int WIDE_W  = 72;
    localparam int ROOT_W  = 36;
    localparam int SREM_W  = 38;
    localparam int DREM_W  = 38;
    localparam int QUO_W   = 17;
    localparam int SCORE_W = 18;

    // iteration counts of the shared arithmetic
    localparam int STEP_W     = 6;
    localparam int MUL_STEPS  = 36;
    localparam int SQRT_STEPS = 36;
    localparam int DIV_STEPS  = 17;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LAG   = 1'b0,
        CFG_THRESHOLD = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_COLLECT,
        S_LAG_INIT,
        S_MAC_RD,
        S_MAC_MUL,
        S_MAC_ACC,
        S_MUL_INIT,
        S_MUL,
        S_SQRT_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_SCORE,
        S_PICK,
        S_OUT,
        S_OUT_LD,
        S_HIST_RD,
        S_HIST_SH
    } t_state;

    typedef enum logic [1:0] {
        LAG_SEARCH,
        LAG_STEER,
        LAG_ZERO
    } t_lag_mode;

    typedef struct packed {
        logic                    wr_frame;
        logic                    rd_issue;
        t_lag_mode               lag_mode;
        logic signed [LAG_W-1:0] lag;
        logic [CNT_W-1:0]        idx;
        logic                    mac_clear;
        logic                    mac_mul;
        logic                    mac_acc;
        logic                    mul_init;
        logic                    mul_step;
        logic                    sqrt_init;
        logic                    sqrt_step;
        logic                    div_init;
        logic                    div_step;
        logic                    score_upd;
        logic                    first;
        logic                    pick;
        logic                    out_load;
        logic                    out_last;
        logic                    hist_shift;
    } t_cmd;

    typedef struct packed {
        logic                out_busy;
        logic [MAXLAG_W-1:0] eff_lag;
    } t_status;

endpackage

// ----- hdl/tmdsb_ram.sv -----
`timescale 1ns / 1ps

module tmdsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tmdsb_ctrl.sv -----
`timescale 1ns / 1ps

module tmdsb_ctrl import tmdsb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_frame_last,
    input  logic    i_track,
    input  t_status i_status,
    output logic    o_ready,
    output t_cmd    o_cmd
);

    t_state                  r_state, n_state;
    logic [FRAME_AW-1:0]     r_fill, n_fill;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic signed [LAG_W-1:0] r_lag, n_lag;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [1:0]              r_cnt, n_cnt;
    logic                    r_first, n_first;
    logic signed [LAG_W-1:0] w_lim;

    assign w_lim = $signed({1'b0, i_status.eff_lag});

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_fill  <= '0;
            r_n     <= '0;
            r_idx   <= '0;
            r_lag   <= '0;
            r_step  <= '0;
            r_cnt   <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_n     <= n_n;
            r_idx   <= n_idx;
            r_lag   <= n_lag;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_first <= n_first;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_n            = r_n;
        n_idx          = r_idx;
        n_lag          = r_lag;
        n_step         = r_step;
        n_cnt          = r_cnt;
        n_first        = r_first;
        o_ready        = 1'b0;
        o_cmd          = '0;
        o_cmd.lag_mode = LAG_SEARCH;
        o_cmd.lag      = r_lag;
        o_cmd.idx      = r_idx;
        case (r_state)
            S_COLLECT: begin
                o_ready   = 1'b1;
                o_cmd.idx = {1'b0, r_fill};
                if (i_valid) begin
                    o_cmd.wr_frame = 1'b1;
                    if (i_frame_last || r_fill == FRAME_AW'(FRAME_MAX - 1)) begin
                        n_n     = {1'b0, r_fill} + CNT_W'(1);
                        n_fill  = '0;
                        n_idx   = '0;
                        n_state = S_OUT;
                        if (i_track) begin
                            n_cnt = r_cnt + 2'd1;
                            if (r_cnt == 2'd3) begin
                                if (i_status.eff_lag == '0) begin
                                    n_state = S_PICK;
                                end else begin
                                    n_lag   = -w_lim;
                                    n_first = 1'b1;
                                    n_state = S_LAG_INIT;
                                end
                            end
                        end
                    end else begin
                        n_fill = r_fill + FRAME_AW'(1);
                    end
                end
            end
            S_LAG_INIT: begin
                o_cmd.mac_clear = 1'b1;
                n_idx           = '0;
                n_state         = S_MAC_RD;
            end
            S_MAC_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_MAC_MUL;
            end
            S_MAC_MUL: begin
                o_cmd.mac_mul = 1'b1;
                n_state       = S_MAC_ACC;
            end
            S_MAC_ACC: begin
                o_cmd.mac_acc = 1'b1;
                if (r_idx + CNT_W'(2) >= r_n) begin
                    n_state = S_MUL_INIT;
                end else begin
                    n_idx   = r_idx + CNT_W'(2);
                    n_state = S_MAC_RD;
                end
            end
            S_MUL_INIT: begin
                o_cmd.mul_init = 1'b1;
                n_step         = '0;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_step          = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_SCORE;
                end
            end
            S_SCORE: begin
                o_cmd.score_upd = 1'b1;
                o_cmd.first     = r_first;
                n_first         = 1'b0;
                if (r_lag == w_lim) begin
                    n_state = S_PICK;
                end else begin
                    n_lag   = r_lag + LAG_W'(1);
                    n_state = S_LAG_INIT;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_idx      = '0;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_cmd.lag_mode = LAG_STEER;
                if (!i_status.out_busy) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                o_cmd.lag_mode = LAG_STEER;
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = (r_idx == r_n - CNT_W'(1));
                if (r_idx == r_n - CNT_W'(1)) begin
                    n_idx   = (r_n > CNT_W'(HIST_DEPTH)) ? r_n - CNT_W'(HIST_DEPTH) : '0;
                    n_state = S_HIST_RD;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_OUT;
                end
            end
            S_HIST_RD: begin
                o_cmd.lag_mode = LAG_ZERO;
                o_cmd.rd_issue = 1'b1;
                n_state        = S_HIST_SH;
            end
            S_HIST_SH: begin
                o_cmd.hist_shift = 1'b1;
                if (r_idx + CNT_W'(1) == r_n) begin
                    n_state = S_COLLECT;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_HIST_RD;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

endmodule

// ----- hdl/tmdsb_dpath.sv -----
`timescale 1ns / 1ps

module tmdsb_dpath import tmdsb_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_mic_a,
    input  logic signed [SAMPLE_W-1:0] i_mic_b,
    input  t_cmd                       i_cmd,
    input  logic                       i_ready,
    output t_status                    o_status,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_beam_out,
    output logic                       o_out_last,
    output logic signed [LAG_W-1:0]    o_steer_lag_now
);

    logic [MAXLAG_W-1:0]        r_max_lag;
    logic [THR_W-1:0]           r_thr;
    logic [MAXLAG_W-1:0]        w_eff;
    logic signed [LAG_W-1:0]    r_steer;
    logic signed [SAMPLE_W-1:0] r_hist_a [0:HIST_DEPTH-1];
    logic signed [SAMPLE_W-1:0] r_hist_b [0:HIST_DEPTH-1];

    logic signed [LAG_W-1:0]    w_lag;
    logic signed [7:0]          w_i, w_d, w_ka, w_kb;
    logic [SAMPLE_W-1:0]        w_ram_a, w_ram_b;
    logic signed [SAMPLE_W-1:0] r_ha_q, r_hb_q;
    logic                       r_use_ha, r_use_hb;
    logic signed [SAMPLE_W-1:0] w_x, w_y;

    logic signed [PROD_W-1:0]   w_pxy, w_pxx, w_pyy;
    logic signed [PROD_W-1:0]   r_pxy;
    logic [SQ_W-1:0]            r_pxx, r_pyy;
    logic signed [XY_W-1:0]     r_xy;
    logic [ACC_W-1:0]           r_aa, r_bb;

    logic [WIDE_W-1:0]          r_prod;
    logic [ACC_W-1:0]           r_mcand, r_mplier;
    logic [ACC_W:0]             w_msum;

    logic [SREM_W-1:0]          r_srem;
    logic [ROOT_W-1:0]          r_root;
    logic [SREM_W+1:0]          w_st, w_strial;
    logic                       w_sge;

    logic [XY_W-1:0]            w_negxy;
    logic [ACC_W-1:0]           w_absxy;
    logic [DREM_W-1:0]          r_drem, w_ddiff, w_dvsr;
    logic                       w_dge;
    logic [QUO_W-1:0]           r_quo;

    logic signed [SCORE_W-1:0]  w_score, r_best;
    logic signed [LAG_W-1:0]    r_best_lag, w_target;

    logic signed [SAMPLE_W:0]   w_sum;
    logic                       r_ovalid, r_olast;
    logic signed [SAMPLE_W-1:0] r_beam;
    logic signed [LAG_W-1:0]    r_ostr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lag <= '0;
            r_thr     <= THR_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_LAG:   r_max_lag <= i_cfg_data[MAXLAG_W-1:0];
                CFG_THRESHOLD: r_thr     <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // search range limited to the history depth
    assign w_eff = (r_max_lag > MAXLAG_W'(LAG_CAP)) ? MAXLAG_W'(LAG_CAP) : r_max_lag;
    assign o_status.eff_lag  = w_eff;
    assign o_status.out_busy = r_ovalid;

    // lag used for the current read
    always_comb begin
        case (i_cmd.lag_mode)
            LAG_SEARCH: w_lag = i_cmd.lag;
            LAG_STEER:  w_lag = r_steer;
            default:    w_lag = '0;
        endcase
    end

    // aligned sample positions, negative ones fall into the history
    assign w_i  = $signed({1'b0, i_cmd.idx});
    assign w_d  = {{(8 - LAG_W){w_lag[LAG_W-1]}}, w_lag};
    assign w_ka = w_lag[LAG_W-1] ? w_i + w_d : w_i;
    assign w_kb = w_lag[LAG_W-1] ? w_i : w_i - w_d;

    tmdsb_ram #(.WIDTH(SAMPLE_W), .DEPTH(FRAME_MAX)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_frame),
        .i_waddr (i_cmd.idx[FRAME_AW-1:0]),
        .i_wdata (i_mic_a),
        .i_raddr (w_ka[FRAME_AW-1:0]),
        .o_rdata (w_ram_a)
    );

    tmdsb_ram #(.WIDTH(SAMPLE_W), .DEPTH(FRAME_MAX)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_frame),
        .i_waddr (i_cmd.idx[FRAME_AW-1:0]),
        .i_wdata (i_mic_b),
        .i_raddr (w_kb[FRAME_AW-1:0]),
        .o_rdata (w_ram_b)
    );

    // history read registered alongside the frame store read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_ha_q   <= r_hist_a[w_ka[HIST_AW-1:0]];
            r_hb_q   <= r_hist_b[w_kb[HIST_AW-1:0]];
            r_use_ha <= w_ka[7];
            r_use_hb <= w_kb[7];
        end
    end

    assign w_x = r_use_ha ? r_ha_q : $signed(w_ram_a);
    assign w_y = r_use_hb ? r_hb_q : $signed(w_ram_b);

    // products then sums
    assign w_pxy = w_x * w_y;
    assign w_pxx = w_x * w_x;
    assign w_pyy = w_y * w_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_mul) begin
            r_pxy <= w_pxy;
            r_pxx <= w_pxx[SQ_W-1:0];
            r_pyy <= w_pyy[SQ_W-1:0];
        end
        if (i_cmd.mac_clear) begin
            r_xy <= '0;
            r_aa <= ACC_W'(1);
            r_bb <= ACC_W'(1);
        end else if (i_cmd.mac_acc) begin
            r_xy <= r_xy + {{(XY_W - PROD_W){r_pxy[PROD_W-1]}}, r_pxy};
            r_aa <= r_aa + {{(ACC_W - SQ_W){1'b0}}, r_pxx};
            r_bb <= r_bb + {{(ACC_W - SQ_W){1'b0}}, r_pyy};
        end
    end

    // shift-add multiplier for the energy product, one bit a cycle
    assign w_msum = {1'b0, r_prod[WIDE_W-1:ACC_W]} + {1'b0, (r_mplier[0] ? r_mcand : '0)};

    // restoring square root, two radicand bits a cycle
    assign w_st     = {r_srem, r_prod[WIDE_W-1:WIDE_W-2]};
    assign w_strial = {2'b00, r_root, 2'b01};
    assign w_sge    = (w_st >= w_strial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_init) begin
            r_prod   <= '0;
            r_mcand  <= r_aa;
            r_mplier <= r_bb;
        end else if (i_cmd.mul_step) begin
            r_prod   <= {w_msum, r_prod[ACC_W-1:1]};
            r_mplier <= {1'b0, r_mplier[ACC_W-1:1]};
        end else if (i_cmd.sqrt_step) begin
            r_prod   <= {r_prod[WIDE_W-3:0], 2'b00};
        end
        if (i_cmd.sqrt_init) begin
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_srem <= w_sge ? SREM_W'(w_st - w_strial) : SREM_W'(w_st);
            r_root <= {r_root[ROOT_W-2:0], w_sge};
        end
    end

    // restoring division of the scaled correlation by the root
    assign w_negxy = -r_xy;
    assign w_absxy = r_xy[XY_W-1] ? w_negxy[ACC_W-1:0] : r_xy[ACC_W-1:0];
    assign w_dvsr  = {{(DREM_W - ROOT_W){1'b0}}, r_root};
    assign w_dge   = (r_drem >= w_dvsr);
    assign w_ddiff = w_dge ? r_drem - w_dvsr : r_drem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_drem <= {{(DREM_W - ACC_W){1'b0}}, w_absxy};
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            r_drem <= {w_ddiff[DREM_W-2:0], 1'b0};
            r_quo  <= {r_quo[QUO_W-2:0], w_dge};
        end
    end

    // signed score and best lag, ties keep the earlier lag
    assign w_score = r_xy[XY_W-1] ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    always_ff @(posedge i_clk) begin
        if (i_cmd.score_upd && (i_cmd.first || w_score > r_best)) begin
            r_best     <= w_score;
            r_best_lag <= i_cmd.lag;
        end
    end

    // target lag, zero when the search range is empty
    always_comb begin
        if (w_eff == '0) begin
            w_target = '0;
        end else if (r_best > $signed({2'b00, r_thr})) begin
            w_target = r_best_lag;
        end else begin
            w_target = r_steer;
        end
    end

    // steering lag steps one sample toward the target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer <= '0;
        end else if (i_cmd.pick) begin
            if (w_target > r_steer) begin
                r_steer <= r_steer + LAG_W'(1);
            end else if (w_target < r_steer) begin
                r_steer <= r_steer - LAG_W'(1);
            end
        end
    end

    // history keeps the true last samples of each channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < HIST_DEPTH; j++) begin
                r_hist_a[j] <= '0;
                r_hist_b[j] <= '0;
            end
        end else if (i_cmd.hist_shift) begin
            for (int j = 0; j < HIST_DEPTH - 1; j++) begin
                r_hist_a[j] <= r_hist_a[j+1];
                r_hist_b[j] <= r_hist_b[j+1];
            end
            r_hist_a[HIST_DEPTH-1] <= $signed(w_ram_a);
            r_hist_b[HIST_DEPTH-1] <= $signed(w_ram_b);
        end
    end

    // output register
    assign w_sum = {w_x[SAMPLE_W-1], w_x} + {w_y[SAMPLE_W-1], w_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_beam  <= w_sum[SAMPLE_W:1];
            r_olast <= i_cmd.out_last;
            r_ostr  <= r_steer;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_beam_out      = r_beam;
    assign o_out_last      = r_olast;
    assign o_steer_lag_now = r_ostr;

endmodule

// ----- hdl/two_mic_delay_sum_beamformer_core.sv -----
`timescale 1ns / 1ps

// Two-microphone delay-and-sum beamformer. Sample pairs are taken one per cycle
// into a 64-entry frame store until a request with frame_last set (or the 64th)
// closes the frame; the block then stops taking requests while it works. On
// every fourth tracked frame it searches lags -L..L, running per lag a
// correlation loop (read, multiply, accumulate) over the even samples of the
// frame and then the shared bit-serial multiplier, square root and divider.
// The frame is then read back one result at a time, limited by the registered
// read of the frame store and the wait for the output register to empty, and
// the history is refreshed with one read and one shift per sample for up to 16
// samples.
module two_mic_delay_sum_beamformer_core import tmdsb_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_mic_a,
    input  logic signed [SAMPLE_W-1:0] i_mic_b,
    input  logic                       i_frame_last,
    input  logic                       i_track,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_beam_out,
    output logic                       o_out_last,
    output logic signed [LAG_W-1:0]    o_steer_lag_now
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    tmdsb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_frame_last (i_frame_last),
        .i_track      (i_track),
        .i_status     (w_status),
        .o_ready      (o_ready),
        .o_cmd        (w_cmd)
    );

    // storage and arithmetic
    tmdsb_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_mic_a         (i_mic_a),
        .i_mic_b         (i_mic_b),
        .i_cmd           (w_cmd),
        .i_ready         (i_ready),
        .o_status        (w_status),
        .o_valid         (o_valid),
        .o_beam_out      (o_beam_out),
        .o_out_last      (o_out_last),
        .o_steer_lag_now (o_steer_lag_now)
    );

endmodule

// ----- hdl/tmdsb_checker.sv -----
`timescale 1ns / 1ps

module tmdsb_checker import tmdsb_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic signed [SAMPLE_W-1:0] o_beam_out,
    input logic                       o_out_last,
    input logic signed [LAG_W-1:0]    o_steer_lag_now
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_beam_out) && $stable(o_out_last))
        else $error("stalled result changed");

    // steering lag stays in the searchable range
    a_lag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_steer_lag_now >= -LAG_W'(LAG_CAP)) &&
                    (o_steer_lag_now <= LAG_W'(LAG_CAP)))
        else $error("steering lag out of range");

    // within a frame the steering lag does not change
    a_lag_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_out_last ##1 o_valid |-> $stable(o_steer_lag_now))
        else $error("steering lag changed inside a frame");

    // no result straight out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind two_mic_delay_sum_beamformer_core tmdsb_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_beam_out      (o_beam_out),
    .o_out_last      (o_out_last),
    .o_steer_lag_now (o_steer_lag_now)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import tmdsb_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] mic_a;
        logic signed [SAMPLE_W-1:0] mic_b;
        logic                       frame_last;
        logic                       track;
    } t_sample_req;

    typedef struct {
        logic signed [SAMPLE_W-1:0] beam;
        logic                       last;
        logic signed [LAG_W-1:0]    lag;
    } t_beam_res;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [CFG_DATA_W-1:0]      i_cfg_data;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_mic_a;
    logic signed [SAMPLE_W-1:0] i_mic_b;
    logic                       i_frame_last;
    logic                       i_track;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [SAMPLE_W-1:0] o_beam_out;
    logic                       o_out_last;
    logic signed [LAG_W-1:0]    o_steer_lag_now;

    two_mic_delay_sum_beamformer_core i_dut (.*);

    // pending requests and expected beam outputs
    t_sample_req sample_q[$];
    t_beam_res   beam_q[$];
    int          mismatch_cnt = 0;
    int          watchdog     = 0;
    int          req_total    = 0;
    int          acc_total    = 0;

    // predictor state
    logic [MAXLAG_W-1:0]        pm_max_lag;
    logic [THR_W-1:0]           pm_thresh;
    logic signed [SAMPLE_W-1:0] pm_frame_a [FRAME_MAX];
    logic signed [SAMPLE_W-1:0] pm_frame_b [FRAME_MAX];
    logic signed [SAMPLE_W-1:0] pm_hist_a [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] pm_hist_b [HIST_DEPTH];
    logic signed [LAG_W-1:0]    pm_steer;
    logic [1:0]                 pm_track_cnt;
    int                         pm_fill;

    // signal source for correlated stimulus
    int src_buf [64];
    int src_pos = 0;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // channel sample at frame index k, reaching into history for negative k
    function automatic int chan_sample(bit chan_b, int k);
        if (k >= 0) return chan_b ? int'(pm_frame_b[k]) : int'(pm_frame_a[k]);
        if (k < -HIST_DEPTH) return 0;
        return chan_b ? int'(pm_hist_b[HIST_DEPTH + k]) : int'(pm_hist_a[HIST_DEPTH + k]);
    endfunction

    function automatic void aligned(int i, int d, output int x, output int y);
        if (d >= 0) begin
            x = int'(pm_frame_a[i]);
            y = chan_sample(1'b1, i - d);
        end else begin
            x = chan_sample(1'b0, i + d);
            y = int'(pm_frame_b[i]);
        end
    endfunction

    // normalised cross-correlation lag search over even samples
    function automatic int best_lag(int n);
        int          lim;
        int          best;
        int          x;
        int          y;
        longint      xy;
        longint      score;
        longint      top_score;
        logic [127:0] aa;
        logic [127:0] bb;
        logic [127:0] prod;
        logic [127:0] root;
        logic [127:0] cand;
        logic [63:0]  quo;
        bit          have;
        lim = (pm_max_lag > LAG_CAP) ? LAG_CAP : int'(pm_max_lag);
        if (lim > HIST_DEPTH) lim = HIST_DEPTH;
        if (lim < 1) return 0;
        best = 0;
        top_score = 0;
        have = 0;
        for (int lag = -lim; lag <= lim; lag++) begin
            xy = 0;
            aa = 128'd1;
            bb = 128'd1;
            for (int i = 0; i < n; i += 2) begin
                aligned(i, lag, x, y);
                xy += longint'(x) * y;
                aa += 128'(longint'(x) * x);
                bb += 128'(longint'(y) * y);
            end
            prod = aa * bb;
            root = '0;
            for (int b = 40; b >= 0; b--) begin
                cand = root | (128'd1 << b);
                if (cand * cand <= prod) root = cand;
            end
            quo = (64'(xy < 0 ? -xy : xy) << 16) / root[63:0];
            score = (xy < 0) ? -longint'(quo) : longint'(quo);
            if (!have || score > top_score) begin
                have = 1;
                top_score = score;
                best = lag;
            end
        end
        return (top_score > longint'(pm_thresh)) ? best : int'(pm_steer);
    endfunction

    // frame collection, steering update, beam outputs and history refresh
    function automatic void predict_sample(t_sample_req r);
        int                         n;
        int                         target;
        int                         x;
        int                         y;
        int                         src;
        t_beam_res                  res;
        logic signed [SAMPLE_W-1:0] na [HIST_DEPTH];
        logic signed [SAMPLE_W-1:0] nb [HIST_DEPTH];
        if (pm_fill >= FRAME_MAX) pm_fill = 0;
        pm_frame_a[pm_fill] = r.mic_a;
        pm_frame_b[pm_fill] = r.mic_b;
        pm_fill++;
        if (!r.frame_last && pm_fill < FRAME_MAX) return;
        n = pm_fill;
        pm_fill = 0;
        if (r.track) begin
            pm_track_cnt = pm_track_cnt + 2'd1;
            if (pm_track_cnt == 2'd0) begin
                target = best_lag(n);
                if (target > pm_steer) pm_steer = pm_steer + LAG_W'(1);
                else if (target < pm_steer) pm_steer = pm_steer - LAG_W'(1);
            end
        end
        for (int i = 0; i < n; i++) begin
            aligned(i, int'(pm_steer), x, y);
            res.beam = SAMPLE_W'((x + y) >>> 1);
            res.last = (i == n - 1);
            res.lag  = pm_steer;
            beam_q.push_back(res);
        end
        for (int j = 0; j < HIST_DEPTH; j++) begin
            src = n - HIST_DEPTH + j;
            na[j] = (src >= 0) ? pm_frame_a[src] : pm_hist_a[n + j];
            nb[j] = (src >= 0) ? pm_frame_b[src] : pm_hist_b[n + j];
        end
        pm_hist_a = na;
        pm_hist_b = nb;
    endfunction

    // idle draw with bursts of back-to-back traffic
    bit drv_burst = 0;
    bit rcv_burst = 0;
    int drv_gap   = 0;
    int rcv_gap   = 0;

    function automatic int draw_drv_gap();
        if ($urandom_range(0, 15) == 0) drv_burst = !drv_burst;
        return drv_burst ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic int draw_rcv_gap();
        if ($urandom_range(0, 15) == 0) rcv_burst = !rcv_burst;
        return rcv_burst ? 0 : $urandom_range(0, 18);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        int          wait_n;
        t_sample_req r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            drv_gap <= 0;
        end else if (!i_valid || o_ready) begin
            wait_n = i_valid ? draw_drv_gap() : drv_gap;
            if (wait_n == 0 && sample_q.size() > 0) begin
                r = sample_q.pop_front();
                i_mic_a      <= r.mic_a;
                i_mic_b      <= r.mic_b;
                i_frame_last <= r.frame_last;
                i_track      <= r.track;
                i_valid      <= 1'b1;
                drv_gap      <= 0;
            end else begin
                i_valid <= 1'b0;
                drv_gap <= (wait_n > 0) ? wait_n - 1 : 0;
            end
        end
    end

    // prediction on each accepted request
    always @(posedge i_clk) begin
        t_sample_req r;
        if (i_rst_n && i_valid && o_ready) begin
            r.mic_a      = i_mic_a;
            r.mic_b      = i_mic_b;
            r.frame_last = i_frame_last;
            r.track      = i_track;
            predict_sample(r);
            acc_total++;
        end
    end

    // output back-pressure
    always @(posedge i_clk) begin
        int wait_n;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rcv_gap <= 0;
        end else begin
            wait_n = (o_valid && i_ready) ? draw_rcv_gap() : rcv_gap;
            if (wait_n > 0) begin
                i_ready <= 1'b0;
                rcv_gap <= wait_n - 1;
            end else begin
                i_ready <= 1'b1;
                rcv_gap <= 0;
            end
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_beam_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (beam_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected output beam=%0d last=%0d lag=%0d",
                             o_beam_out, o_out_last, o_steer_lag_now);
            end else begin
                e = beam_q.pop_front();
                if (o_beam_out !== e.beam || o_out_last !== e.last
                        || o_steer_lag_now !== e.lag) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("output mismatch: exp beam=%0d last=%0d lag=%0d, got beam=%0d last=%0d lag=%0d",
                                 e.beam, e.last, e.lag,
                                 o_beam_out, o_out_last, o_steer_lag_now);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) watchdog <= 0;
        else watchdog <= watchdog + 1;
        if (watchdog >= 40000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] clamp16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return SAMPLE_W'(v);
    endfunction

    function automatic void push_sample(int a, int b, bit last, bit trk);
        t_sample_req r;
        r.mic_a = clamp16(a);
        r.mic_b = clamp16(b);
        r.frame_last = last;
        r.track = trk;
        sample_q.push_back(r);
        req_total++;
    endfunction

    // kind 0: delayed copy with noise, 1: uncorrelated noise, 2: full-scale extremes
    function automatic void push_frame(int len, bit trk, int kind, int delay, bit mark_last);
        int s;
        int a;
        int b;
        int noise;
        for (int i = 0; i < len; i++) begin
            s = $urandom_range(0, 1) ? $urandom_range(0, 65535) - 32768
                                     : $urandom_range(0, 4095) - 2048;
            src_buf[src_pos & 63] = s;
            noise = $urandom_range(0, 63) - 32;
            case (kind)
                0: begin
                    if (delay >= 0) begin
                        a = s;
                        b = src_buf[(src_pos - delay) & 63] + noise;
                    end else begin
                        b = s;
                        a = src_buf[(src_pos + delay) & 63] + noise;
                    end
                end
                1: begin
                    a = $urandom_range(0, 65535) - 32768;
                    b = $urandom_range(0, 65535) - 32768;
                end
                default: begin
                    a = $urandom_range(0, 1) ? 32767 : -32768;
                    b = $urandom_range(0, 1) ? 32767 : -32768;
                end
            endcase
            src_pos++;
            push_sample(a, b, mark_last && (i == len - 1), trk);
        end
    endfunction

    task automatic cfg_write(t_cfg_idx idx, int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        if (idx == CFG_MAX_LAG) pm_max_lag = MAXLAG_W'(value);
        else pm_thresh = THR_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every request is taken and every result is out
    task automatic drain();
        while (acc_total < req_total || beam_q.size() > 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic random_frames(int n_frames);
        int len;
        for (int f = 0; f < n_frames; f++) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(32, 63)
                                               : $urandom_range(1, 8);
            push_frame(len, $urandom_range(0, 7) != 0,
                       ($urandom_range(0, 5) == 0) ? 1 : 0,
                       $urandom_range(0, 12) - 6, 1'b1);
        end
    endtask

    initial begin
        int lag_set [5]  = '{16, 3, 31, 8, 0};
        int thr_set [5]  = '{0, 65535, 20000, 9830, 65535};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_MAX_LAG;
        i_cfg_data   = '0;
        i_mic_a      = '0;
        i_mic_b      = '0;
        i_frame_last = 1'b0;
        i_track      = 1'b0;
        pm_max_lag   = '0;
        pm_thresh    = THR_RESET;
        pm_steer     = '0;
        pm_track_cnt = '0;
        pm_fill      = 0;
        foreach (pm_hist_a[k]) begin
            pm_hist_a[k] = '0;
            pm_hist_b[k] = '0;
        end
        foreach (src_buf[k]) src_buf[k] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero search range at reset values: extremes, single-sample frame, full frame
        push_sample(-32768, -32768, 1'b1, 1'b1);
        push_sample(32767, 32767, 1'b0, 1'b1);
        push_sample(32767, -32768, 1'b1, 1'b1);
        push_frame(3, 1'b1, 2, 0, 1'b1);
        push_frame(2, 1'b1, 0, 0, 1'b1);
        push_frame(FRAME_MAX, 1'b0, 1, 0, 1'b0);
        drain();

        // tracking with a wide search and zero threshold, short frames
        cfg_write(CFG_MAX_LAG, 16);
        cfg_write(CFG_THRESHOLD, 0);
        for (int f = 0; f < 8; f++) push_frame(2 + (f & 1), 1'b1, 0, 5, 1'b1);
        drain();

        // random phases over several settings
        for (int p = 0; p < 5; p++) begin
            cfg_write(CFG_MAX_LAG, lag_set[p]);
            cfg_write(CFG_THRESHOLD, thr_set[p]);
            random_frames(1);
            drain();
        end
        while (req_total < 120) begin
            cfg_write(CFG_MAX_LAG, $urandom_range(0, 31));
            cfg_write(CFG_THRESHOLD, $urandom_range(0, 1) ? $urandom_range(0, 8000)
                                                          : $urandom_range(0, 65535));
            random_frames(1);
            drain();
        end

        if (mismatch_cnt == 0 && beam_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tmdsb_pkg.sv
hdl/tmdsb_ram.sv
hdl/tmdsb_ctrl.sv
hdl/tmdsb_dpath.sv
hdl/two_mic_delay_sum_beamformer_core.sv
hdl/tmdsb_checker.sv
bench/tb.sv
